// ----- hw/rtl/kst_pkg.sv -----
package kst_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int EDGE_SLOTS   = 512;
  localparam int WEIGHT_BITS  = 20;

  localparam int VTX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(EDGE_SLOTS + 1);
  localparam int VC_W   = 6;
  localparam int COST_W = 25;
  localparam int ADDR_W = 3;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [VC_W-1:0]   NV_MAX   = VC_W'(MAX_VERTICES);

  // register index taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [VTX_W-1:0]       a;
    logic [VTX_W-1:0]       b;
    logic [WEIGHT_BITS-1:0] w;
  } edge_t;

  // broadcast to every sort cell
  typedef struct packed {
    logic  clear;
    logic  insert;
    logic  pop;
    edge_t new_edge;
  } sort_ctl_t;

  // broadcast to every label cell
  typedef struct packed {
    logic             init;
    logic             merge;
    logic [VTX_W-1:0] la;
    logic [VTX_W-1:0] lb;
  } label_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } state_t;

endpackage

// ----- hw/rtl/kst_in_if.sv -----
interface kst_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] row_index;
  logic [4:0] column_index;
  logic [19:0] edge_weight;
  logic       last_entry;

  modport source (output valid, row_index, column_index, edge_weight, last_entry,
                  input ready);
  modport sink   (input valid, row_index, column_index, edge_weight, last_entry,
                  output ready);
endinterface

// ----- hw/rtl/kst_out_if.sv -----
interface kst_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [5:0]  first_vertex;
  logic [5:0]  second_vertex;
  logic [19:0] tree_edge_weight;
  logic [24:0] tree_cost;
  logic        store_overflow;
  logic        last_result;

  modport source (output valid, item_kind, first_vertex, second_vertex, tree_edge_weight,
                  tree_cost, store_overflow, last_result, input ready);
  modport sink   (input valid, item_kind, first_vertex, second_vertex, tree_edge_weight,
                  tree_cost, store_overflow, last_result, output ready);
endinterface

// ----- hw/rtl/kst_sort_cell.sv -----
module kst_sort_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  kst_pkg::sort_ctl_t ctl,
  input  kst_pkg::edge_t    left_edge,
  input  logic              left_valid,
  input  logic              left_open,
  input  kst_pkg::edge_t    right_edge,
  input  logic              right_valid,
  output kst_pkg::edge_t    edge_r,
  output logic              valid_r,
  output logic              open
);

  kst_pkg::edge_t edge_nxt;
  logic           valid_nxt;

  // open: the new edge belongs here or further left (equal weights stay ahead)
  assign open = !valid_r || (edge_r.w > ctl.new_edge.w);

  always_comb begin
    edge_nxt  = edge_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.insert && open) begin
      if (!left_open) begin
        edge_nxt  = ctl.new_edge;
        valid_nxt = 1'b1;
      end else begin
        edge_nxt  = left_edge;
        valid_nxt = left_valid;
      end
    end else if (ctl.pop) begin
      edge_nxt  = right_edge;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    edge_r <= edge_nxt;
  end

endmodule

// ----- hw/rtl/kst_label_cell.sv -----
module kst_label_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kst_pkg::label_ctl_t        ctl,
  input  logic [kst_pkg::VTX_W-1:0]  cell_idx,
  output logic [kst_pkg::VTX_W-1:0]  lab_r
);

  logic [kst_pkg::VTX_W-1:0] lab_nxt;

  always_comb begin
    lab_nxt = lab_r;
    if (ctl.init) begin
      lab_nxt = cell_idx;
    end else if (ctl.merge && (lab_r == ctl.la)) begin
      lab_nxt = ctl.lb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lab_r <= cell_idx;
    end else begin
      lab_r <= lab_nxt;
    end
  end

endmodule

// ----- hw/rtl/kruskal_spanning_tree_top.sv -----
// Minimum spanning tree engine (Kruskal).
// in_ch: adjacency matrix entries, one transfer per cycle while loading. Entries
//   above the diagonal with non-zero weight and both vertices below vertex_count
//   are inserted into a sorted row of cells while it has free slots.
// The transfer marked last_entry closes the graph: in_ch.ready drops and the
//   engine pops one edge from the head of the row per cycle while the output
//   register is free, checking it against per-vertex component labels. A scan
//   stops popping once vertex_count-1 edges are taken or the row is empty.
// out_ch: tree edges in ascending weight order, then a summary item with
//   last_result set. Results sit in an output register; when the receiver
//   stalls the scan holds. After the summary the row is emptied and in_ch.ready
//   returns.
// Config: APB write of vertex_count at address 0 while idle.
// Reset: row empty, counts and cost zero, vertex_count = 2.
module kruskal_spanning_tree_top (
  input  logic                          clk,
  input  logic                          rst_n,
  kst_in_if.sink                        in_ch,
  kst_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kst_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int SLOTS = kst_pkg::EDGE_SLOTS;
  localparam int NV    = kst_pkg::MAX_VERTICES;
  localparam int VW    = kst_pkg::VTX_W;

  kst_pkg::state_t state_r, state_nxt;

  logic [kst_pkg::VC_W-1:0]   vc_r;
  logic [kst_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [kst_pkg::VC_W-1:0]   acc_r, acc_nxt;
  logic [kst_pkg::VC_W-1:0]   target_r, target_nxt;
  logic [kst_pkg::COST_W-1:0] cost_r, cost_nxt;
  logic                       ovf_r, ovf_nxt;

  logic                       ov_r, ov_nxt;
  logic                       o_kind_r, o_kind_nxt;
  logic [5:0]                 o_a_r, o_a_nxt, o_b_r, o_b_nxt;
  logic [19:0]                o_w_r, o_w_nxt;
  logic [kst_pkg::COST_W-1:0] o_cost_r, o_cost_nxt;
  logic                       o_ovf_r, o_ovf_nxt;
  logic                       o_last_r, o_last_nxt;

  kst_pkg::sort_ctl_t  sctl;
  kst_pkg::label_ctl_t lctl;

  kst_pkg::edge_t edge_q  [SLOTS];
  logic           valid_q [SLOTS];
  logic           open_q  [SLOTS];
  logic [VW-1:0]  lab_q   [NV];

  logic [kst_pkg::VC_W-1:0]   nv;
  logic                       acc_in, keep, slot_free, cfg_wr;
  logic [kst_pkg::COST_W:0]   sum_w;
  kst_pkg::edge_t             head;
  logic [VW-1:0]              la, lb;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == kst_pkg::REG_VERTEX_COUNT);
  assign prdata = (paddr[2] == kst_pkg::REG_VERTEX_COUNT) ?
                  {{(32-kst_pkg::VC_W){1'b0}}, vc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= kst_pkg::VC_W'(2);
    end else if (cfg_wr) begin
      vc_r <= pwdata[kst_pkg::VC_W-1:0];
    end
  end

  assign nv     = (vc_r > kst_pkg::NV_MAX) ? kst_pkg::NV_MAX : vc_r;
  assign in_ch.ready = (state_r == kst_pkg::ST_LOAD);
  assign acc_in = in_ch.valid && in_ch.ready;
  assign keep   = (in_ch.column_index > in_ch.row_index) && (in_ch.edge_weight != '0) &&
                  ({1'b0, in_ch.column_index} < nv);
  assign slot_free = !ov_r || out_ch.ready;

  // sorted row
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_sort
      if (gi == 0) begin : g_head
        kst_sort_cell u_cell (
          .clk, .rst_n, .ctl(sctl),
          .left_edge(sctl.new_edge), .left_valid(1'b0), .left_open(1'b0),
          .right_edge(edge_q[(SLOTS > 1) ? 1 : 0]),
          .right_valid((SLOTS > 1) ? valid_q[(SLOTS > 1) ? 1 : 0] : 1'b0),
          .edge_r(edge_q[gi]), .valid_r(valid_q[gi]), .open(open_q[gi]));
      end else if (gi == SLOTS - 1) begin : g_tail
        kst_sort_cell u_cell (
          .clk, .rst_n, .ctl(sctl),
          .left_edge(edge_q[gi-1]), .left_valid(valid_q[gi-1]), .left_open(open_q[gi-1]),
          .right_edge(edge_q[gi]), .right_valid(1'b0),
          .edge_r(edge_q[gi]), .valid_r(valid_q[gi]), .open(open_q[gi]));
      end else begin : g_mid
        kst_sort_cell u_cell (
          .clk, .rst_n, .ctl(sctl),
          .left_edge(edge_q[gi-1]), .left_valid(valid_q[gi-1]), .left_open(open_q[gi-1]),
          .right_edge(edge_q[gi+1]), .right_valid(valid_q[gi+1]),
          .edge_r(edge_q[gi]), .valid_r(valid_q[gi]), .open(open_q[gi]));
      end
    end
    for (gi = 0; gi < NV; gi++) begin : g_lab
      kst_label_cell u_cell (
        .clk, .rst_n, .ctl(lctl), .cell_idx(VW'(gi)), .lab_r(lab_q[gi]));
    end
  endgenerate

  assign head  = edge_q[0];
  assign la    = lab_q[head.a];
  assign lb    = lab_q[head.b];
  assign sum_w = {1'b0, cost_r} + (kst_pkg::COST_W+1)'(head.w);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    target_nxt = target_r;
    cost_nxt   = cost_r;
    ovf_nxt    = ovf_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_kind_nxt = o_kind_r;
    o_a_nxt    = o_a_r;
    o_b_nxt    = o_b_r;
    o_w_nxt    = o_w_r;
    o_cost_nxt = o_cost_r;
    o_ovf_nxt  = o_ovf_r;
    o_last_nxt = o_last_r;
    sctl.clear    = 1'b0;
    sctl.insert   = 1'b0;
    sctl.pop      = 1'b0;
    sctl.new_edge.a = in_ch.row_index;
    sctl.new_edge.b = in_ch.column_index;
    sctl.new_edge.w = in_ch.edge_weight;
    lctl.init  = 1'b0;
    lctl.merge = 1'b0;
    lctl.la    = la;
    lctl.lb    = lb;
    case (state_r)
      kst_pkg::ST_LOAD: begin
        if (acc_in) begin
          if (keep) begin
            if (cnt_r < kst_pkg::CNT_W'(SLOTS)) begin
              sctl.insert = 1'b1;
              cnt_nxt     = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_ch.last_entry) begin
            lctl.init  = 1'b1;
            acc_nxt    = '0;
            cost_nxt   = '0;
            target_nxt = (nv == '0) ? '0 : nv - 1'b1;
            state_nxt  = kst_pkg::ST_SCAN;
          end
        end
      end
      kst_pkg::ST_SCAN: begin
        if (slot_free) begin
          if ((cnt_r != '0) && (acc_r < target_r)) begin
            sctl.pop = 1'b1;
            cnt_nxt  = cnt_r - 1'b1;
            if (la != lb) begin
              lctl.merge = 1'b1;
              acc_nxt    = acc_r + 1'b1;
              cost_nxt   = sum_w[kst_pkg::COST_W] ? kst_pkg::COST_MAX
                                                  : sum_w[kst_pkg::COST_W-1:0];
              ov_nxt     = 1'b1;
              o_kind_nxt = kst_pkg::KIND_EDGE;
              o_a_nxt    = 6'(head.a) + 6'd1;
              o_b_nxt    = 6'(head.b) + 6'd1;
              o_w_nxt    = head.w;
              o_cost_nxt = cost_nxt;
              o_ovf_nxt  = ovf_r;
              o_last_nxt = 1'b0;
            end
          end else begin
            ov_nxt     = 1'b1;
            o_kind_nxt = kst_pkg::KIND_SUMMARY;
            o_a_nxt    = '0;
            o_b_nxt    = '0;
            o_w_nxt    = '0;
            o_cost_nxt = cost_r;
            o_ovf_nxt  = ovf_r;
            o_last_nxt = 1'b1;
            sctl.clear = 1'b1;
            cnt_nxt    = '0;
            acc_nxt    = '0;
            cost_nxt   = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = kst_pkg::ST_LOAD;
          end
        end
      end
      default: state_nxt = kst_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= kst_pkg::ST_LOAD;
      cnt_r    <= '0;
      acc_r    <= '0;
      target_r <= '0;
      cost_r   <= '0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      target_r <= target_nxt;
      cost_r   <= cost_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
    end
    o_kind_r <= o_kind_nxt;
    o_a_r    <= o_a_nxt;
    o_b_r    <= o_b_nxt;
    o_w_r    <= o_w_nxt;
    o_cost_r <= o_cost_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.item_kind        = o_kind_r;
  assign out_ch.first_vertex     = o_a_r;
  assign out_ch.second_vertex    = o_b_r;
  assign out_ch.tree_edge_weight = o_w_r;
  assign out_ch.tree_cost        = o_cost_r;
  assign out_ch.store_overflow   = o_ovf_r;
  assign out_ch.last_result      = o_last_r;

endmodule

// ----- hw/rtl/kst_checker.sv -----
module kst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [5:0] out_first,
  input logic [5:0] out_second,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_last))
    else $error("input closed without a last transfer");

  // summary is in the output register when input reopens
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid && out_last)
    else $error("input reopened without a summary pending");

  a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_first != 6'd0) && (out_first < out_second) && !out_kind)
    else $error("malformed tree edge");

endmodule

bind kruskal_spanning_tree_top kst_checker u_kst_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_entry),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.item_kind),
  .out_first(out_ch.first_vertex), .out_second(out_ch.second_vertex),
  .out_last(out_ch.last_result)
);
